>>> rtl/core/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes and tables for the seven-segment command display.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int FRAME_BYTES = 30;
  localparam int ROWS        = 3;
  localparam int COLUMNS     = 6;
  localparam int CHAR_COUNT  = ROWS * COLUMNS;
  localparam int FB_W        = $clog2(FRAME_BYTES);
  localparam int PAT_W       = $clog2(CHAR_COUNT);
  localparam int OUT_W       = 40;
  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] IDLE_RESET   = 16'd300;
  localparam logic [7:0]  BEEP_RESET   = 8'd10;
  localparam logic [7:0]  DOT_SEG      = 8'h80;
  localparam logic [7:0]  MINUS_GLYPH  = 8'h40;
  localparam logic [31:0] POS_MAX      = 32'd999999;
  localparam logic [31:0] POS_MIN      = -32'sd99999;
  localparam logic [19:0] POS_MIN_MAG  = 20'd99999;
  localparam int          POSITION_LEN = 14;
  localparam int          BEEP_LEN     = 3;

  // Input opcodes.
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_BYTE  = 3'd1;
  localparam logic [2:0] OP_END   = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_SCAN  = 3'd4;

  // Command bytes.
  localparam logic [7:0] CMD_POSITION = 8'h10;
  localparam logic [7:0] CMD_TEXT     = 8'h20;
  localparam logic [7:0] CMD_BEEP     = 8'h30;
  localparam logic [7:0] CMD_CLEAR    = 8'h50;
  localparam logic [7:0] CMD_RESET    = 8'h70;
  localparam logic [7:0] CMD_VERSION  = 8'h05;

  // Reported command codes.
  localparam logic [2:0] DONE_NONE     = 3'd0;
  localparam logic [2:0] DONE_CLEAR    = 3'd1;
  localparam logic [2:0] DONE_VERSION  = 3'd2;
  localparam logic [2:0] DONE_BEEP     = 3'd3;
  localparam logic [2:0] DONE_POSITION = 3'd4;
  localparam logic [2:0] DONE_TEXT     = 3'd5;
  localparam logic [2:0] DONE_RESET    = 3'd6;

  typedef enum logic [2:0] {
    KIND_START,
    KIND_BYTE,
    KIND_END,
    KIND_TICK,
    KIND_SCAN,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRC_RD,
    ST_CRC_USE,
    ST_EXEC,
    ST_POS_RD,
    ST_POS_USE,
    ST_POS_CLAMP,
    ST_POS_DIG,
    ST_TXT_RD,
    ST_TXT_USE,
    ST_DONE
  } state_t;

  localparam logic [7:0] GLYPH [95] = '{
    8'h00,8'hB0,8'h22,8'h00,8'h00,8'h00,8'h00,8'h20,8'h39,8'h15,8'h00,8'h00,8'h80,8'h40,8'h80,8'hB6,
    8'h3F,8'h06,8'h5B,8'h4F,8'h66,8'h6D,8'h7D,8'h07,8'h7F,8'h6F,8'h00,8'h00,8'h00,8'h48,8'h00,8'h00,
    8'h00,8'h77,8'h7F,8'h39,8'h5E,8'h79,8'h71,8'h7D,8'h76,8'h06,8'h1E,8'h75,8'h38,8'h15,8'h37,8'h3F,
    8'h73,8'h6B,8'h33,8'h6D,8'h78,8'h3E,8'h3E,8'h2A,8'h76,8'h6E,8'h5B,8'h39,8'h64,8'h15,8'h23,8'h08,
    8'h20,8'h5F,8'h7C,8'h58,8'h5E,8'h7B,8'h71,8'h6F,8'h74,8'h10,8'h1E,8'h75,8'h30,8'h15,8'h54,8'h5C,
    8'h73,8'h67,8'h50,8'h6D,8'h78,8'h1C,8'h1C,8'h2A,8'h76,8'h6E,8'h5B,8'h39,8'hB0,8'h15,8'h01
  };

  // Patterns of the text "VErS. 0.0.1 rEAdy ".
  localparam logic [7:0] VERSION_PAT [CHAR_COUNT] = '{
    8'h3E,8'h79,8'h50,8'h6D,8'h80,8'h00,8'h3F,8'h80,8'h3F,
    8'h80,8'h06,8'h00,8'h50,8'h79,8'h77,8'h5E,8'h6E,8'h00
  };

  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'h3F,8'h06,8'h5B,8'h4F,8'h66,8'h6D,8'h7D,8'h07,8'h7F,8'h6F
  };

  function automatic logic [7:0] to_glyph(input logic [7:0] c);
    logic [6:0] off;
    off = 7'(c - 8'd32);
    if (c >= 8'd32 && c <= 8'd126) begin
      return GLYPH[off];
    end
    return 8'h00;
  endfunction

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [OUT_W-1:0] pack_result(
    input logic        scan_valid,
    input logic [31:0] scan_bits,
    input logic        frame_accepted,
    input logic [2:0]  command_done,
    input logic        blank_strobe,
    input logic        beeper_on
  );
    return {1'b0, beeper_on, blank_strobe, command_done, frame_accepted, scan_bits,
            scan_valid};
  endfunction

endpackage

>>> rtl/core/seven_segment_command_display_unit.sv
// ----------------------------------------------------------------------------
// seven_segment_command_display_unit
// SPI command frames, timeout and beep timing, and segment scan words.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one output transfer. Frame start, byte,
// tick, scan and unused opcodes, and an end with no stored bytes, are handled
// from the idle state. A frame end walks the stored bytes through the CRC
// with a read and a use state per byte (one frame buffer read port); on a
// CRC match it runs the command: text reads and copies each character, position
// reads four bytes per row, clamps and writes up to six digits (five and a
// minus sign if negative). A four-entry input queue and a registered output
// let the input side keep transferring while a result waits to be taken.
module seven_segment_command_display_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] scan_valid, [32:1] scan_bits, [33] frame_accepted, [36:34] command_done,
  // [37] blank_strobe, [38] beeper_on, [39] zero
  output logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import ssd_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  ssd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  ssd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

>>> rtl/core/ssd_front.sv
// ----------------------------------------------------------------------------
// ssd_front
// Accepts input transfers, classifies the opcode and queues the items.
// ----------------------------------------------------------------------------
module ssd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,  // data_byte
  input  logic [2:0]    s_tuser,  // opcode
  output logic          q_valid,
  input  logic          q_ready,
  output ssd_pkg::item_t q_item
);
  import ssd_pkg::*;

  item_t             queue [QUEUE_DEPTH];
  logic [QP_W-1:0]   wr_ptr;
  logic [QP_W-1:0]   rd_ptr;
  logic [QP_W:0]     fill;
  item_t             new_item;
  logic              push;
  logic              pop;

  always_comb begin
    new_item.data = s_tdata;
    case (s_tuser)
      OP_START: new_item.kind = KIND_START;
      OP_BYTE:  new_item.kind = KIND_BYTE;
      OP_END:   new_item.kind = KIND_END;
      OP_TICK:  new_item.kind = KIND_TICK;
      OP_SCAN:  new_item.kind = KIND_SCAN;
      default:  new_item.kind = KIND_NOP;
    endcase
  end

  assign s_tready = (fill != (QP_W+1)'(QUEUE_DEPTH));
  assign q_valid  = (fill != '0);
  assign q_item   = queue[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_item;
    end
  end

endmodule

>>> rtl/core/ssd_back.sv
// ----------------------------------------------------------------------------
// ssd_back
// Executes queued items: frame capture, CRC check, commands, ticks, scan.
// ----------------------------------------------------------------------------
module ssd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  ssd_pkg::item_t    q_item,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [ssd_pkg::OUT_W-1:0] m_tdata
);
  import ssd_pkg::*;

  localparam logic [19:0] DIV10_MUL = 20'hCCCCD;

  state_t            state;
  state_t            state_next;

  logic [7:0]        frame_store [FRAME_BYTES];
  logic [7:0]        rd_data;
  logic [FB_W-1:0]   frame_count;
  logic              frame_open;
  logic [7:0]        pat [CHAR_COUNT];
  logic [7:0]        active_segment;
  logic [15:0]       idle_timeout;
  logic [15:0]       idle_remaining;
  logic [7:0]        beep_remaining;
  logic              beeper_level;

  logic              out_valid;
  logic [OUT_W-1:0]  out_data;
  logic              can_load;
  logic              load_simple;
  logic              pop;

  logic [FB_W-1:0]   n_len;
  logic [FB_W-1:0]   idx;
  logic [7:0]        crc;
  logic [7:0]        cmd;
  logic [7:0]        arg;
  logic              res_acc;
  logic [2:0]        res_code;
  logic              res_blank;
  logic [1:0]        row;
  logic [1:0]        kcnt;
  logic [31:0]       word;
  logic [19:0]       mag;
  logic              neg;
  logic [2:0]        col;
  logic [PAT_W-1:0]  tlen;

  logic [31:0]       scan_word;
  logic [39:0]       prod;
  logic [19:0]       quot;
  logic [19:0]       quot10;
  logic [3:0]        digit;
  logic [PAT_W-1:0]  row_base;
  logic [FB_W-1:0]   n_minus1;
  logic              end_walk;
  logic              last_digit;

  assign can_load = !out_valid || m_tready;
  assign n_minus1 = n_len - 1'b1;
  assign row_base = PAT_W'({row, 2'b00}) + PAT_W'({row, 1'b0});
  assign last_digit = (col == {2'b00, neg});

  // Divide by ten through a reciprocal multiply; exact for six-digit values.
  assign prod   = mag * DIV10_MUL;
  assign quot   = 20'(prod[39:23]);
  assign quot10 = {quot[16:0], 3'b000} + {quot[18:0], 1'b0};
  assign digit  = 4'(mag - quot10);

  always_comb begin
    scan_word = '0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLUMNS; c++) begin
        scan_word[31 - (r * 8 + c)] =
          |(pat[(ROWS - 1 - r) * COLUMNS + (COLUMNS - 1 - c)] & active_segment);
      end
    end
    scan_word[7:0] = active_segment;
  end

  // A frame end with stored bytes goes through the CRC walk; all else is handled from idle.
  assign end_walk = (q_item.kind == KIND_END) && (frame_count != '0);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid && can_load && end_walk) begin
          state_next = ST_CRC_RD;
        end
      end
      ST_CRC_RD:  state_next = ST_CRC_USE;
      ST_CRC_USE: begin
        if (idx == n_minus1) begin
          state_next = (rd_data == crc) ? ST_EXEC : ST_DONE;
        end else begin
          state_next = ST_CRC_RD;
        end
      end
      ST_EXEC: begin
        state_next = ST_DONE;
        if (cmd == CMD_POSITION && n_len == FB_W'(POSITION_LEN)) begin
          state_next = ST_POS_RD;
        end else if (cmd == CMD_TEXT && n_len > FB_W'(2)) begin
          state_next = ST_TXT_RD;
        end
      end
      ST_POS_RD:    state_next = ST_POS_USE;
      ST_POS_USE:   state_next = (kcnt == 2'd3) ? ST_POS_CLAMP : ST_POS_RD;
      ST_POS_CLAMP: state_next = ST_POS_DIG;
      ST_POS_DIG: begin
        if (last_digit) begin
          state_next = (row == 2'd2) ? ST_DONE : ST_POS_RD;
        end
      end
      ST_TXT_RD:  state_next = ST_TXT_USE;
      ST_TXT_USE: state_next = (int'(idx) == int'(tlen)) ? ST_DONE : ST_TXT_RD;
      ST_DONE:    state_next = can_load ? ST_IDLE : ST_DONE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready     = (state == ST_IDLE) && can_load;
    pop         = q_valid && q_ready;
    load_simple = pop && !end_walk;
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.kind == KIND_BYTE && frame_open) begin
      frame_store[frame_count] <= q_item.data;
    end
    rd_data <= frame_store[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      frame_count    <= '0;
      frame_open     <= 1'b0;
      active_segment <= 8'h01;
      idle_timeout   <= IDLE_RESET;
      idle_remaining <= IDLE_RESET;
      beep_remaining <= BEEP_RESET;
      beeper_level   <= 1'b1;
      out_valid      <= 1'b0;
      pat            <= VERSION_PAT;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        idle_timeout <= cfg_wdata;
      end
      if (load_simple || (state == ST_DONE && can_load)) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (pop) begin
            case (q_item.kind)
              KIND_START: begin
                frame_open  <= 1'b1;
                frame_count <= '0;
              end
              KIND_BYTE: begin
                if (frame_open) begin
                  frame_count <= (frame_count == FB_W'(FRAME_BYTES - 1)) ? '0
                                 : frame_count + 1'b1;
                end
              end
              KIND_END: begin
                frame_open  <= 1'b0;
                frame_count <= '0;
              end
              KIND_TICK: begin
                if (idle_remaining != '0) begin
                  idle_remaining <= idle_remaining - 1'b1;
                  if (idle_remaining == 16'd1) begin
                    for (int i = 0; i < CHAR_COUNT; i++) begin
                      pat[i] <= '0;
                    end
                  end
                end
                if (beep_remaining != '0) begin
                  beep_remaining <= beep_remaining - 1'b1;
                  if (beep_remaining == 8'd1) begin
                    beeper_level <= 1'b0;
                  end
                end
              end
              KIND_SCAN: begin
                active_segment <= (active_segment[7]) ? 8'h01 : {active_segment[6:0], 1'b0};
              end
              default: begin
              end
            endcase
          end
        end
        ST_EXEC: begin
          case (cmd)
            CMD_RESET, CMD_CLEAR: begin
              for (int i = 0; i < CHAR_COUNT; i++) begin
                pat[i] <= '0;
              end
            end
            CMD_VERSION: begin
              pat            <= VERSION_PAT;
              idle_remaining <= idle_timeout;
            end
            CMD_BEEP: begin
              if (n_len == FB_W'(BEEP_LEN)) begin
                beep_remaining <= arg;
                beeper_level   <= 1'b1;
                idle_remaining <= idle_timeout;
              end
            end
            CMD_TEXT: begin
              if (n_len == FB_W'(2)) begin
                idle_remaining <= idle_timeout;
              end
            end
            default: begin
            end
          endcase
        end
        ST_POS_CLAMP: begin
          if ($signed(word) < $signed(POS_MIN) || word[31]) begin
            pat[row_base] <= MINUS_GLYPH;
          end
        end
        ST_POS_DIG: begin
          pat[row_base + PAT_W'(col)] <= DIGIT_GLYPH[digit] |
                                         ((col == 3'd2) ? DOT_SEG : 8'h00);
          if (last_digit && row == 2'd2) begin
            idle_remaining <= idle_timeout;
          end
        end
        ST_TXT_USE: begin
          pat[PAT_W'(idx - 1'b1)] <= to_glyph(rd_data);
          if (int'(idx) == int'(tlen)) begin
            idle_remaining <= idle_timeout;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of the frame-end walk, and the output result data.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        n_len     <= frame_count;
        idx       <= '0;
        crc       <= '0;
        res_acc   <= 1'b0;
        res_code  <= DONE_NONE;
        res_blank <= 1'b0;
        if (load_simple) begin
          case (q_item.kind)
            KIND_TICK: begin
              out_data <= pack_result(1'b0, 32'd0, 1'b0, DONE_NONE,
                                      idle_remaining == 16'd1,
                                      (beep_remaining == 8'd1) ? 1'b0 : beeper_level);
            end
            KIND_SCAN: begin
              out_data <= pack_result(1'b1, scan_word, 1'b0, DONE_NONE, 1'b0, beeper_level);
            end
            default: begin
              out_data <= pack_result(1'b0, 32'd0, 1'b0, DONE_NONE, 1'b0, beeper_level);
            end
          endcase
        end
      end
      ST_CRC_USE: begin
        if (idx == '0) begin
          cmd <= rd_data;
        end
        if (idx == FB_W'(1)) begin
          arg <= rd_data;
        end
        if (idx == n_minus1) begin
          res_acc <= (rd_data == crc);
        end else begin
          crc <= crc_update(crc, rd_data);
          idx <= idx + 1'b1;
        end
      end
      ST_EXEC: begin
        row  <= '0;
        kcnt <= '0;
        idx  <= FB_W'(1);
        tlen <= (n_len - FB_W'(2) > FB_W'(CHAR_COUNT)) ? PAT_W'(CHAR_COUNT)
                : PAT_W'(n_len - FB_W'(2));
        case (cmd)
          CMD_RESET: begin
            res_code  <= DONE_RESET;
            res_blank <= 1'b1;
          end
          CMD_CLEAR: begin
            res_code  <= DONE_CLEAR;
            res_blank <= 1'b1;
          end
          CMD_VERSION: res_code <= DONE_VERSION;
          CMD_BEEP: begin
            if (n_len == FB_W'(BEEP_LEN)) begin
              res_code <= DONE_BEEP;
            end
          end
          CMD_TEXT: begin
            if (n_len >= FB_W'(2)) begin
              res_code <= DONE_TEXT;
            end
          end
          CMD_POSITION: begin
            if (n_len == FB_W'(POSITION_LEN)) begin
              res_code <= DONE_POSITION;
            end
          end
          default: begin
          end
        endcase
      end
      ST_POS_USE: begin
        word <= {word[23:0], rd_data};
        idx  <= idx + 1'b1;
        kcnt <= kcnt + 1'b1;
      end
      ST_POS_CLAMP: begin
        col <= 3'd5;
        if ($signed(word) > $signed(POS_MAX)) begin
          mag <= POS_MAX[19:0];
          neg <= 1'b0;
        end else if ($signed(word) < $signed(POS_MIN)) begin
          mag <= POS_MIN_MAG;
          neg <= 1'b1;
        end else if (word[31]) begin
          mag <= 20'(-word);
          neg <= 1'b1;
        end else begin
          mag <= word[19:0];
          neg <= 1'b0;
        end
      end
      ST_POS_DIG: begin
        mag <= quot;
        col <= col - 1'b1;
        if (last_digit) begin
          row  <= row + 1'b1;
          kcnt <= '0;
        end
      end
      ST_TXT_USE: begin
        idx <= idx + 1'b1;
      end
      ST_DONE: begin
        // The finished result is loaded only once the output register is free.
        if (can_load) begin
          out_data <= pack_result(1'b0, 32'd0, res_acc, res_code, res_blank, beeper_level);
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

>>> rtl/core/ssd_checker.sv
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks on the result stream of the display unit.
// ----------------------------------------------------------------------------
module ssd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  // A scan result never reports a frame or a blanking.
  a_scan_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[33] && m_tdata[36:34] == 3'd0 && !m_tdata[37])
    else $error("scan result carries frame status");

  // A command is reported only for an accepted frame.
  a_cmd_accepted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[36:34] != 3'd0 |-> m_tdata[33])
    else $error("command without accepted frame");

  // Scan bits stay zero outside a scan result, and the pad bit stays zero.
  a_scan_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[39] && (m_tdata[0] || m_tdata[32:1] == 32'd0))
    else $error("stray scan bits");

endmodule

bind seven_segment_command_display_unit ssd_checker u_ssd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> test/tb_seven_segment_command_display_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_command_display_unit
// Checks the seven-segment command display against a behavioral predictor.
// SPI frames, ticks and scan steps are streamed in under several idling
// patterns. Every result transfer is compared field by field with the
// predicted one.
// ----------------------------------------------------------------------------
module tb_seven_segment_command_display_unit;
  import ssd_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  seven_segment_command_display_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Predictor state.
  logic [15:0] p_timeout;
  logic [7:0]  p_frame [FRAME_BYTES];
  int          p_count;
  bit          p_open;
  logic [7:0]  p_chars [CHAR_COUNT];
  logic [7:0]  p_seg;
  logic [15:0] p_idle;
  logic [7:0]  p_beep;
  logic        p_beeper;

  logic [39:0] expected_results [$];
  int          errors;
  int          checked;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_start;
  int          hold_cycles = 0;
  int          sent;

  initial begin
    clk = 0;
  end
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic [7:0] seg_of(input logic [7:0] c);
    logic [7:0] g [95];
    g = '{
      8'h00,8'hB0,8'h22,8'h00,8'h00,8'h00,8'h00,8'h20,8'h39,8'h15,8'h00,8'h00,8'h80,8'h40,
      8'h80,8'hB6,8'h3F,8'h06,8'h5B,8'h4F,8'h66,8'h6D,8'h7D,8'h07,8'h7F,8'h6F,8'h00,8'h00,
      8'h00,8'h48,8'h00,8'h00,8'h00,8'h77,8'h7F,8'h39,8'h5E,8'h79,8'h71,8'h7D,8'h76,8'h06,
      8'h1E,8'h75,8'h38,8'h15,8'h37,8'h3F,8'h73,8'h6B,8'h33,8'h6D,8'h78,8'h3E,8'h3E,8'h2A,
      8'h76,8'h6E,8'h5B,8'h39,8'h64,8'h15,8'h23,8'h08,8'h20,8'h5F,8'h7C,8'h58,8'h5E,8'h7B,
      8'h71,8'h6F,8'h74,8'h10,8'h1E,8'h75,8'h30,8'h15,8'h54,8'h5C,8'h73,8'h67,8'h50,8'h6D,
      8'h78,8'h1C,8'h1C,8'h2A,8'h76,8'h6E,8'h5B,8'h39,8'hB0,8'h15,8'h01
    };
    if (c >= 8'd32 && c <= 8'd126) return g[c - 8'd32];
    return 8'h00;
  endfunction

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
    return c;
  endfunction

  function automatic void load_banner();
    string t;
    t = "VErS. 0.0.1 rEAdy ";
    for (int i = 0; i < CHAR_COUNT; i++) p_chars[i] = seg_of(t[i]);
  endfunction

  function automatic void blank_chars();
    for (int i = 0; i < CHAR_COUNT; i++) p_chars[i] = 8'h00;
  endfunction

  function automatic void predict_reset();
    p_timeout = 16'd300;
    for (int i = 0; i < FRAME_BYTES; i++) p_frame[i] = 8'h00;
    p_count = 0;
    p_open = 0;
    load_banner();
    p_seg = 8'h01;
    p_idle = 16'd300;
    p_beep = 8'd10;
    p_beeper = 1'b1;
  endfunction

  function automatic void render_row(input int row, input int base);
    logic [31:0] u;
    longint v;
    longint mag;
    int first;
    u = {p_frame[base], p_frame[base+1], p_frame[base+2], p_frame[base+3]};
    v = longint'($signed(u));
    if (v > 999999) v = 999999;
    if (v < -99999) v = -99999;
    first = 0;
    if (v < 0) begin
      p_chars[row*COLUMNS] = seg_of("-");
      mag = -v;
      first = 1;
    end else begin
      mag = v;
    end
    for (int i = COLUMNS - 1; i >= first; i--) begin
      p_chars[row*COLUMNS + i] = seg_of(8'(48 + mag % 10));
      mag = mag / 10;
    end
    p_chars[row*COLUMNS + 2] |= 8'h80;
  endfunction

  // Computes the result of one input transfer and advances the predictor.
  function automatic logic [39:0] predict_display(input logic [2:0] op, input logic [7:0] b);
    logic        sv, acc, blank;
    logic [2:0]  done;
    logic [31:0] w;
    logic [7:0]  crc;
    int          n, len;
    sv = 0; acc = 0; blank = 0; done = DONE_NONE; w = 0;
    case (op)
      OP_START: begin
        p_open = 1;
        p_count = 0;
      end
      OP_BYTE: begin
        if (p_open) begin
          if (p_count >= FRAME_BYTES) p_count = 0;
          p_frame[p_count] = b;
          p_count = (p_count + 1) % FRAME_BYTES;
        end
      end
      OP_END: begin
        n = p_count;
        p_open = 0;
        p_count = 0;
        crc = 0;
        if (n != 0) begin
          for (int i = 0; i + 1 < n; i++) crc = crc8_step(crc, p_frame[i]);
          if (p_frame[n-1] == crc) begin
            acc = 1;
            case (p_frame[0])
              CMD_RESET, CMD_CLEAR: begin
                blank_chars();
                blank = 1;
                done = (p_frame[0] == CMD_RESET) ? DONE_RESET : DONE_CLEAR;
              end
              CMD_VERSION: begin
                load_banner();
                p_idle = p_timeout;
                done = DONE_VERSION;
              end
              CMD_BEEP: begin
                if (n == BEEP_LEN) begin
                  p_beep = p_frame[1];
                  p_beeper = 1;
                  p_idle = p_timeout;
                  done = DONE_BEEP;
                end
              end
              CMD_POSITION: begin
                if (n == POSITION_LEN) begin
                  for (int r = 0; r < ROWS; r++) render_row(r, 1 + 4*r);
                  p_idle = p_timeout;
                  done = DONE_POSITION;
                end
              end
              CMD_TEXT: begin
                if (n >= 2) begin
                  len = n - 2;
                  if (len > CHAR_COUNT) len = CHAR_COUNT;
                  for (int i = 0; i < len; i++) p_chars[i] = seg_of(p_frame[i+1]);
                  p_idle = p_timeout;
                  done = DONE_TEXT;
                end
              end
              default: ;
            endcase
          end
        end
      end
      OP_TICK: begin
        if (p_idle > 0) begin
          p_idle--;
          if (p_idle == 0) begin
            blank_chars();
            blank = 1;
          end
        end
        if (p_beep > 0) begin
          p_beep--;
          if (p_beep == 0) p_beeper = 0;
        end
      end
      OP_SCAN: begin
        for (int r = 0; r < ROWS; r++) begin
          for (int c = 0; c < COLUMNS; c++)
            w = (w << 1) | (((p_chars[(ROWS-1-r)*COLUMNS + (COLUMNS-1-c)] & p_seg) != 0));
          w = w << 2;
        end
        w = (w << 8) | p_seg;
        sv = 1;
        p_seg = p_seg << 1;
        if (p_seg == 0) p_seg = 8'h01;
      end
      default: ;
    endcase
    return {1'b0, p_beeper, blank, done, acc, w, sv};
  endfunction

  // The valid line stays up between back-to-back items; it drops only while
  // the sender idles or the stream is drained.
  task automatic send_item(input logic [2:0] op, input logic [7:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(predict_display(op, b));
    sent++;
  endtask

  // Sends a whole frame; a correct checksum byte is appended when good_crc is set, an inverted one otherwise.
  task automatic send_frame(input logic [7:0] bytes [$], input bit good_crc);
    logic [7:0] crc;
    crc = 0;
    send_item(OP_START, 8'($urandom));
    foreach (bytes[i]) begin
      send_item(OP_BYTE, bytes[i]);
      crc = crc8_step(crc, bytes[i]);
    end
    send_item(OP_BYTE, good_crc ? crc : ~crc);
    send_item(OP_END, 8'($urandom));
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    p_timeout = v;
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        logic [39:0] e;
        e = expected_results.pop_front();
        checked++;
        if (e[0] !== m_tdata[0] || e[32:1] !== m_tdata[32:1] || e[33] !== m_tdata[33] ||
            e[36:34] !== m_tdata[36:34] || e[37] !== m_tdata[37] ||
            e[38] !== m_tdata[38]) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, m_tdata);
          errors++;
        end
      end
    end
  end

  // Result-side stall pattern and the long hold-off, which runs once after it
  // is requested.
  always @(posedge clk) begin
    if (hold_start && hold_cycles < 300) begin
      m_tready <= 0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic test_directed();
    logic [7:0] q [$];
    repeat (8) send_item(OP_SCAN, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(3'd5, 8'h00);
    send_item(3'd7, 8'hFF);
    send_item(OP_END, 8'h00);
    q = '{CMD_BEEP, 8'd0}; send_frame(q, 1'b1);
    q = '{CMD_POSITION, 8'h7F,8'hFF,8'hFF,8'hFF, 8'h80,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h30,8'h39};
    send_frame(q, 1'b1);
    repeat (8) send_item(OP_SCAN, 8'h00);
    q = '{CMD_TEXT, 8'h00, 8'h7F, 8'h20, 8'h7E};
    send_frame(q, 1'b1);
    q = '{CMD_CLEAR}; send_frame(q, 1'b0);
    q = '{CMD_RESET}; send_frame(q, 1'b1);
    q = '{CMD_VERSION}; send_frame(q, 1'b1);
    q = '{8'h99}; send_frame(q, 1'b1);
    q = '{CMD_BEEP}; send_frame(q, 1'b1);
  endtask

  task automatic test_long_text();
    logic [7:0] q [$];
    q = '{CMD_TEXT};
    for (int i = 0; i < 27; i++) q.push_back(8'($urandom_range(20, 130)));
    send_frame(q, 1'b1);
    // Overflow: more bytes than the store holds.
    q = '{CMD_TEXT};
    for (int i = 0; i < 40; i++) q.push_back(8'($urandom));
    send_frame(q, $urandom_range(1) != 0);
    repeat (6) send_item(OP_SCAN, 8'h00);
  endtask

  task automatic test_timeout();
    logic [7:0] q [$];
    write_timeout(16'd1);
    q = '{CMD_VERSION}; send_frame(q, 1'b1);
    repeat (3) send_item(OP_TICK, 8'h00);
    write_timeout(16'd0);
    q = '{CMD_VERSION}; send_frame(q, 1'b1);
    repeat (3) send_item(OP_TICK, 8'h00);
    write_timeout(16'hFFFF);
    q = '{CMD_BEEP, 8'd255}; send_frame(q, 1'b1);
    repeat (4) send_item(OP_TICK, 8'h00);
  endtask

  task automatic test_random(input int count);
    logic [7:0] q [$];
    int kind;
    int start;
    start = sent;
    while (sent - start < count) begin
      kind = $urandom_range(9);
      q = {};
      case (kind)
        0: begin
          q.push_back(CMD_POSITION);
          for (int i = 0; i < 12; i++) q.push_back(8'($urandom));
          send_frame(q, $urandom_range(9) != 0);
        end
        1: begin
          q.push_back(CMD_TEXT);
          repeat ($urandom_range(0, 22)) q.push_back(8'($urandom));
          send_frame(q, $urandom_range(9) != 0);
        end
        2: begin
          q = '{CMD_BEEP, 8'($urandom_range(0, 12))};
          send_frame(q, 1'b1);
        end
        3: begin
          case ($urandom_range(3))
            0: q = '{CMD_CLEAR};
            1: q = '{CMD_RESET};
            2: q = '{CMD_VERSION};
            default: q = '{8'($urandom)};
          endcase
          repeat ($urandom_range(0, 2)) q.push_back(8'($urandom));
          send_frame(q, $urandom_range(4) != 0);
        end
        4, 5: repeat ($urandom_range(1, 10)) send_item(OP_TICK, 8'($urandom));
        6, 7: repeat ($urandom_range(1, 16)) send_item(OP_SCAN, 8'($urandom));
        default: send_item(3'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    s_tuser = 0;
    m_tready = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    errors = 0;
    checked = 0;
    sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_start = 0;
    predict_reset();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_long_text();
    test_timeout();
    write_timeout(16'd40);
    test_random(500);
    send_idle_pct = 74;
    test_random(400);
    send_idle_pct = 0;
    recv_stall_pct = 74;
    write_timeout(16'd300);
    test_random(400);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    hold_start = 1;
    test_random(400);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_timeout(16'd3);
    test_random(300);
    drain();
    $display("Ran %0d input transfers and checked %0d results", sent, checked);
    $display("across frames, ticks, scans, idle timeouts and stalls.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
rtl/core/ssd_pkg.sv
rtl/core/ssd_front.sv
rtl/core/ssd_back.sv
rtl/core/seven_segment_command_display_unit.sv
rtl/core/ssd_checker.sv
test/tb_seven_segment_command_display_unit.sv
